// ===== src/sacl_pkg.sv =====
// shared codes for the set-associative cache lru simulator
// holds access kinds, outcome codes, register indexes and back-end states
// no dependencies
package sacl_pkg;

	localparam int NWAY_W = 5;

	localparam logic [1:0] OP_FETCH  = 2'd0;
	localparam logic [1:0] OP_LOAD   = 2'd1;
	localparam logic [1:0] OP_STORE  = 2'd2;
	localparam logic [1:0] OP_MODIFY = 2'd3;

	localparam logic [1:0] OC_HIT   = 2'd0;
	localparam logic [1:0] OC_FILL  = 2'd1;
	localparam logic [1:0] OC_EVICT = 2'd2;
	localparam logic [1:0] OC_NONE  = 2'd3;

	localparam logic [1:0] REG_SET_BITS    = 2'd0;
	localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS        = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACC1,
		ST_ACC2
	} bstate_t;

endpackage

// ===== src/sacl_front.sv =====
// front end: takes words, splits the address into set and tag, queues them
// depends on sacl_pkg
module sacl_front #(
	parameter int MAX_SET_BITS = 6,
	parameter int ADDR_WIDTH = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [1:0]              s_op,
	input  logic [63:0]             s_address,
	input  logic [3:0]              set_bits,
	input  logic [5:0]              offset_bits,
	output logic                    q_valid,
	input  logic                    q_pop,
	output logic [1:0]              q_op,
	output logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] q_set,
	output logic [ADDR_WIDTH-1:0]   q_tag
);
	import sacl_pkg::*;

	localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int ENT_W = 2 + SET_W + ADDR_WIDTH;

	logic [ADDR_WIDTH-1:0] addr;
	logic [ADDR_WIDTH-1:0] by_offset;
	logic [ADDR_WIDTH-1:0] tag;
	logic [6:0]            shift;
	logic [SET_W-1:0]      set_mask;
	logic [SET_W-1:0]      set_idx;
	logic [ENT_W-1:0]      ent_q [2];
	logic                  wp_q;
	logic                  rp_q;
	logic [1:0]            cnt_q;
	logic                  push;

	// address split
	always_comb begin
		addr = s_address[ADDR_WIDTH-1:0];
		shift = 7'(set_bits) + 7'(offset_bits);
		by_offset = addr >> offset_bits;
		tag = (shift >= 7'(ADDR_WIDTH)) ? '0 : (addr >> shift);
		set_mask = ~({SET_W{1'b1}} << set_bits);
		set_idx = by_offset[SET_W-1:0] & set_mask;
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push = s_tvalid && s_tready;
	assign q_valid = (cnt_q != 2'd0);
	assign {q_op, q_set, q_tag} = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= {s_op, set_idx, tag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (q_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

// ===== src/sacl_access.sv =====
// one cache access on a set row: hit search, fill, lru victim and age update
// depends on sacl_pkg
module sacl_access #(
	parameter int WAYS = 8,
	parameter int ADDR_WIDTH = 64
) (
	input  logic [sacl_pkg::NWAY_W-1:0]                           nways,
	input  logic [ADDR_WIDTH-1:0]                                 tag,
	input  logic [WAYS-1:0]                                       vld,
	input  logic [WAYS-1:0][((WAYS > 1) ? $clog2(WAYS) : 1)-1:0]  rank,
	input  logic [WAYS-1:0][ADDR_WIDTH-1:0]                       tags,
	output logic [WAYS-1:0]                                       vld_n,
	output logic [WAYS-1:0][((WAYS > 1) ? $clog2(WAYS) : 1)-1:0]  rank_n,
	output logic [WAYS-1:0][ADDR_WIDTH-1:0]                       tags_n,
	output logic [1:0]                                            outcome
);
	import sacl_pkg::*;

	localparam int WIDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int RANK_W = WIDX_W;

	logic              hit;
	logic              emp;
	logic [WIDX_W-1:0] hw;
	logic [WIDX_W-1:0] ew;
	logic [WIDX_W-1:0] vic;
	logic [WIDX_W-1:0] sel;
	logic [RANK_W-1:0] old;
	logic              age_all;

	always_comb begin
		hit = 1'b0;
		emp = 1'b0;
		hw = '0;
		ew = '0;
		vic = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (NWAY_W'(w) < nways) begin
				if (!hit && vld[w] && tags[w] == tag) begin
					hit = 1'b1;
					hw = WIDX_W'(w);
				end
				if (!emp && !vld[w]) begin
					emp = 1'b1;
					ew = WIDX_W'(w);
				end
				if (w > 0 && rank[w] > rank[vic]) begin
					vic = WIDX_W'(w);
				end
			end
		end

		sel = hit ? hw : (emp ? ew : vic);
		old = rank[sel];
		age_all = !hit && emp;
		outcome = hit ? OC_HIT : (emp ? OC_FILL : OC_EVICT);

		vld_n = vld;
		tags_n = tags;
		rank_n = rank;
		if (!hit) begin
			vld_n[sel] = 1'b1;
			tags_n[sel] = tag;
		end
		// ways in use younger than the touched one age by one (every valid way on a fill), up to WAYS-1
		for (int v = 0; v < WAYS; v++) begin
			if (NWAY_W'(v) < nways && WIDX_W'(v) != sel && vld[v]) begin
				if ((age_all || rank[v] < old) && rank[v] < RANK_W'(WAYS - 1)) begin
					rank_n[v] = rank[v] + 1'b1;
				end
			end
		end
		rank_n[sel] = '0;
	end

endmodule

// ===== src/sacl_back.sv =====
// back end: set row memory, access sequencer, counters and output register
// depends on sacl_pkg and sacl_access
module sacl_back #(
	parameter int MAX_SET_BITS = 6,
	parameter int WAYS = 8,
	parameter int ADDR_WIDTH = 64
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              q_valid,
	output logic                                              q_pop,
	input  logic [1:0]                                        q_op,
	input  logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] q_set,
	input  logic [ADDR_WIDTH-1:0]                             q_tag,
	input  logic [sacl_pkg::NWAY_W-1:0]                       nways,
	output logic                                              m_tvalid,
	input  logic                                              m_tready,
	output logic [1:0]                                        outcome,
	output logic                                              second_hit,
	output logic [31:0]                                       hit_total,
	output logic [31:0]                                       miss_total,
	output logic [31:0]                                       evict_total
);
	import sacl_pkg::*;

	localparam int SETS = 1 << MAX_SET_BITS;
	localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WIDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int RANK_W = WIDX_W;
	localparam int ROW_W = WAYS * (1 + RANK_W + ADDR_WIDTH);

	bstate_t state_q, state_d;

	logic [ROW_W-1:0]      mem [SETS];
	logic [ROW_W-1:0]      rd_row_s1;
	logic                  rok_s1;
	logic [SETS-1:0]       rok_q;
	logic [ROW_W-1:0]      row_q;
	logic [ROW_W-1:0]      src_row;
	logic [ROW_W-1:0]      new_row;
	logic [1:0]            op_q;
	logic [SET_W-1:0]      set_q;
	logic [ADDR_WIDTH-1:0] tag_q;
	logic [1:0]            first_q;

	logic [WAYS-1:0]                   a_vld, n_vld;
	logic [WAYS-1:0][RANK_W-1:0]       a_rank, n_rank;
	logic [WAYS-1:0][ADDR_WIDTH-1:0]   a_tags, n_tags;
	logic [1:0]                        acc_oc;

	logic        can_emit;
	logic        rd_en;
	logic        commit;
	logic        emit;
	logic [31:0] hit_q, miss_q, evict_q;
	logic [31:0] hit_n, miss_n, evict_n;
	logic        m_valid_q;
	logic [1:0]  oc_q;
	logic        sec_q;
	logic [31:0] hit_o_q, miss_o_q, evict_o_q;

	assign src_row = (state_q == ST_ACC2) ? row_q : (rok_s1 ? rd_row_s1 : '0);
	assign {a_vld, a_rank, a_tags} = src_row;
	assign new_row = {n_vld, n_rank, n_tags};

	sacl_access #(
		.WAYS(WAYS),
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_access (
		.nways(nways),
		.tag(tag_q),
		.vld(a_vld),
		.rank(a_rank),
		.tags(a_tags),
		.vld_n(n_vld),
		.rank_n(n_rank),
		.tags_n(n_tags),
		.outcome(acc_oc)
	);

	assign can_emit = !m_valid_q || m_tready;

	always_comb begin
		hit_n = hit_q;
		miss_n = miss_q;
		evict_n = evict_q;
		if (acc_oc == OC_HIT) begin
			if (hit_q != '1) hit_n = hit_q + 32'd1;
		end else begin
			if (miss_q != '1) miss_n = miss_q + 32'd1;
		end
		if (acc_oc == OC_EVICT) begin
			if (evict_q != '1) evict_n = evict_q + 32'd1;
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		rd_en = 1'b0;
		commit = 1'b0;
		emit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (q_op == OP_FETCH) begin
						if (can_emit) begin
							q_pop = 1'b1;
							emit = 1'b1;
						end
					end else begin
						q_pop = 1'b1;
						rd_en = 1'b1;
						state_d = ST_ACC1;
					end
				end
			end
			ST_ACC1: begin
				if (op_q == OP_MODIFY) begin
					commit = 1'b1;
					state_d = ST_ACC2;
				end else if (can_emit) begin
					commit = 1'b1;
					emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_ACC2: begin
				if (can_emit) begin
					commit = 1'b1;
					emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// set row memory, registered read
	always_ff @(posedge clk) begin
		if (commit) begin
			mem[set_q] <= new_row;
		end
		if (rd_en) begin
			rd_row_s1 <= mem[q_set];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q <= q_op;
			set_q <= q_set;
			tag_q <= q_tag;
		end
		if (commit) begin
			row_q <= new_row;
		end
		if (state_q == ST_ACC1) begin
			first_q <= acc_oc;
		end
		if (emit) begin
			if (state_q == ST_IDLE) begin
				oc_q <= OC_NONE;
				sec_q <= 1'b0;
				hit_o_q <= hit_q;
				miss_o_q <= miss_q;
				evict_o_q <= evict_q;
			end else begin
				oc_q <= (state_q == ST_ACC2) ? first_q : acc_oc;
				sec_q <= (state_q == ST_ACC2) && (acc_oc == OC_HIT);
				hit_o_q <= hit_n;
				miss_o_q <= miss_n;
				evict_o_q <= evict_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rok_q <= '0;
			rok_s1 <= 1'b0;
			hit_q <= '0;
			miss_q <= '0;
			evict_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rd_en) begin
				rok_s1 <= rok_q[q_set];
			end
			if (commit) begin
				rok_q[set_q] <= 1'b1;
				hit_q <= hit_n;
				miss_q <= miss_n;
				evict_q <= evict_n;
			end
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign outcome = oc_q;
	assign second_hit = sec_q;
	assign hit_total = hit_o_q;
	assign miss_total = miss_o_q;
	assign evict_total = evict_o_q;

endmodule

// ===== src/set_assoc_cache_lru_sim_top.sv =====
// top level of the set-associative cache lru hit/miss simulator
// depends on sacl_pkg, sacl_front and sacl_back
//
// usage
//  - input stream: s_tuser carries the access kind, s_tdata the byte address;
//    a word moves when s_tvalid and s_tready are both high
//  - output stream: one word per input word; m_tuser holds outcome and the
//    second-access hit flag, m_tdata the three saturating running counters
//  - config: cfg_we writes cfg_data to register cfg_index (0 set index bits,
//    1 offset bits, 2 ways in use); user writes only while block is idle, not enforced
//  - sequencing: a fetch needs no row access; load/store read one set row of the
//    row memory and update it, modify reads it and updates it twice; the back end
//    takes no new word until it is through with the last; a word passes the
//    registered row read (not for fetch) and then the output register
//  - a two-word queue separates the front (address split) from the back, so
//    input keeps flowing while a result waits on m_tready
//  - a stalled receiver holds the back end once the output register is full;
//    input stops once the queue is full too; nothing is dropped
//  - reset clears counters and one valid flag per set; no clearing pass is
//    needed, a set never written reads as all lines invalid
module set_assoc_cache_lru_sim_top #(
	parameter int MAX_SET_BITS = 6,
	parameter int WAYS = 8,
	parameter int ADDR_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // address[63:0]
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // hit_total[31:0], miss_total[63:32], evict_total[95:64]
	output logic [2:0]  m_tuser,   // outcome[1:0], second_hit[2]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data
);
	import sacl_pkg::*;

	localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

	// config registers
	logic [2:0] set_bits_q;
	logic [5:0] offset_q;
	logic [3:0] ways_q;

	logic [3:0]        s_eff;
	logic [NWAY_W-1:0] nways;

	logic                  q_valid;
	logic                  q_pop;
	logic [1:0]            q_op;
	logic [SET_W-1:0]      q_set;
	logic [ADDR_WIDTH-1:0] q_tag;

	logic [1:0]  outcome;
	logic        second_hit;
	logic [31:0] hit_total, miss_total, evict_total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= 3'd0;
			offset_q <= 6'd0;
			ways_q <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SET_BITS:    set_bits_q <= cfg_data[2:0];
				REG_OFFSET_BITS: offset_q <= cfg_data;
				REG_WAYS:        ways_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// clamp set bits to what the memory holds, ways to 1..WAYS
	always_comb begin
		s_eff = ({1'b0, set_bits_q} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
			: {1'b0, set_bits_q};
		nways = {1'b0, ways_q};
		if (nways == '0) begin
			nways = NWAY_W'(1);
		end else if (nways > NWAY_W'(WAYS)) begin
			nways = NWAY_W'(WAYS);
		end
	end

	sacl_front #(
		.MAX_SET_BITS(MAX_SET_BITS),
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_op(s_tuser),
		.s_address(s_tdata),
		.set_bits(s_eff),
		.offset_bits(offset_q),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_op(q_op),
		.q_set(q_set),
		.q_tag(q_tag)
	);

	sacl_back #(
		.MAX_SET_BITS(MAX_SET_BITS),
		.WAYS(WAYS),
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_op(q_op),
		.q_set(q_set),
		.q_tag(q_tag),
		.nways(nways),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.outcome(outcome),
		.second_hit(second_hit),
		.hit_total(hit_total),
		.miss_total(miss_total),
		.evict_total(evict_total)
	);

	assign m_tdata = {evict_total, miss_total, hit_total};
	assign m_tuser = {second_hit, outcome};

endmodule
